[rtl/core/run_combining_group_min_max_table_assert.svh]
// Assertion macros used by the checker file rcgmm_chk.
`ifndef RUN_COMBINING_GROUP_MIN_MAX_TABLE_ASSERT_SVH
`define RUN_COMBINING_GROUP_MIN_MAX_TABLE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define RCGMM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RCGMM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rcgmm_pkg.sv]
// ----------------------------------------------------------------------------
// rcgmm_pkg
// Shared types and constants of the run-combining group min/max table.
// ----------------------------------------------------------------------------
`default_nettype none

package rcgmm_pkg;

  localparam int BUCKET_BITS_DEF = 8;
  localparam int WAYS_DEF        = 4;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  // one way of a bucket row: {key, min, max}
  localparam int ENT_W = KEY_W + 2 * VAL_W;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] min;
    logic [VAL_W-1:0] max;
    logic             kind;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             evict;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] min;
    logic [VAL_W-1:0] max;
  } evict_t;

endpackage

`default_nettype wire

[rtl/core/rcgmm_ram.sv]
// ----------------------------------------------------------------------------
// rcgmm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcgmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/rcgmm_row_upd.sv]
// ----------------------------------------------------------------------------
// rcgmm_row_upd
// Merges a finished run into one bucket row: hit, fill or evict-and-shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rcgmm_row_upd #(
  parameter int WAYS = rcgmm_pkg::WAYS_DEF
) (
  input  wire logic [WAYS*rcgmm_pkg::ENT_W+$clog2(WAYS+1)-1:0] row_in,
  input  wire logic [rcgmm_pkg::KEY_W-1:0]                     run_key,
  input  wire logic [rcgmm_pkg::VAL_W-1:0]                     run_min,
  input  wire logic [rcgmm_pkg::VAL_W-1:0]                     run_max,
  output logic      [WAYS*rcgmm_pkg::ENT_W+$clog2(WAYS+1)-1:0] row_out,
  output rcgmm_pkg::evict_t                                    ev
);

  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int ENT_W = rcgmm_pkg::ENT_W;
  localparam int KEY_W = rcgmm_pkg::KEY_W;
  localparam int VAL_W = rcgmm_pkg::VAL_W;
  localparam int ROW_W = WAYS * ENT_W + CNT_W;

  logic [CNT_W-1:0] cnt;
  logic [WAYS-1:0]  hit;
  logic             full;
  logic [ENT_W-1:0] way_q [WAYS];
  logic [ENT_W-1:0] run_ent;

  assign cnt     = row_in[ROW_W-1 -: CNT_W];
  assign full    = (cnt == CNT_W'(WAYS));
  assign run_ent = {run_key, run_min, run_max};

  // all ways compared at once; valid ways are a prefix of length cnt
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      way_q[i] = row_in[i*ENT_W +: ENT_W];
      hit[i]   = (CNT_W'(i) < cnt) && (way_q[i][ENT_W-1 -: KEY_W] == run_key);
    end
  end

  always_comb begin
    row_out  = row_in;
    ev       = '0;
    ev.key   = way_q[WAYS-1][ENT_W-1 -: KEY_W];
    ev.min   = way_q[WAYS-1][2*VAL_W-1 -: VAL_W];
    ev.max   = way_q[WAYS-1][VAL_W-1:0];
    if (|hit) begin
      for (int i = 0; i < WAYS; i++) begin
        if (hit[i]) begin
          if (way_q[i][2*VAL_W-1 -: VAL_W] > run_min) begin
            row_out[i*ENT_W + VAL_W +: VAL_W] = run_min;
          end
          if (way_q[i][VAL_W-1:0] < run_max) begin
            row_out[i*ENT_W +: VAL_W] = run_max;
          end
        end
      end
    end else if (!full) begin
      for (int i = 0; i < WAYS; i++) begin
        if (CNT_W'(i) == cnt) begin
          row_out[i*ENT_W +: ENT_W] = run_ent;
        end
      end
      row_out[ROW_W-1 -: CNT_W] = cnt + CNT_W'(1);
    end else begin
      ev.evict = 1'b1;
      for (int i = WAYS - 1; i > 0; i--) begin
        row_out[i*ENT_W +: ENT_W] = way_q[i-1];
      end
      row_out[0 +: ENT_W] = run_ent;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rcgmm_obuf.sv]
// ----------------------------------------------------------------------------
// rcgmm_obuf
// Two-entry result buffer driving the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rcgmm_obuf (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire rcgmm_pkg::res_t                   push_res,
  output logic                                   room,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [rcgmm_pkg::KEY_W-1:0]       out_key,
  output logic      [rcgmm_pkg::VAL_W-1:0]       out_min,
  output logic      [rcgmm_pkg::VAL_W-1:0]       out_max,
  output logic                                   out_kind,
  output logic                                   out_last
);

  logic [1:0]      cnt_r, cnt_nxt;
  rcgmm_pkg::res_t slot0_r, slot0_nxt;
  rcgmm_pkg::res_t slot1_r, slot1_nxt;
  logic            pop;

  assign pop  = out_valid && !out_stall;
  assign room = (cnt_r != 2'd2);

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};
    // head refill
    if (pop && (cnt_r == 2'd2)) begin
      slot0_nxt = slot1_r;
    end else if (push && ((cnt_r == 2'd0) || (pop && (cnt_r == 2'd1)))) begin
      slot0_nxt = push_res;
    end
    if (push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop))) begin
      slot1_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_key   = slot0_r.key;
  assign out_min   = slot0_r.min;
  assign out_max   = slot0_r.max;
  assign out_kind  = slot0_r.kind;
  assign out_last  = slot0_r.last;

endmodule

`default_nettype wire

[rtl/core/run_combining_group_min_max_table.sv]
// ----------------------------------------------------------------------------
// run_combining_group_min_max_table
// Group-by min/max with run merging and a set-associative bucket table.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry (group_key, sample_value, last_item). Beats with the
//   same key as the open run fold into it; a key change writes the finished
//   run into bucket group_key[BUCKET_BITS-1:0] of a table held in one RAM,
//   one row per bucket with WAYS ways and a fill count.
//   Output beats are evictions (out_kind 0) and flushes of the open run on a
//   last_item beat (out_kind 1); out_last marks the final beat of an input.
// Sequence: a beat that continues or opens a run is taken in ST_IDLE; a
//   beat that closes a run reads its bucket row, which ST_MOD updates and
//   writes back. Result beats are pushed from ST_EMIT. in_stall is high
//   outside ST_IDLE. The first result follows the beat through ST_EMIT
//   (flush only) or through ST_MOD and ST_EMIT (run closed by the beat).
// Reset: a clearing pass writes every bucket row empty, one row per cycle;
//   in_stall is high until it completes.
// Stalls: results go through a two-entry output buffer, so the next input
//   beat is taken while results wait; processing halts only when the buffer
//   is full.
// ----------------------------------------------------------------------------
`default_nettype none

module run_combining_group_min_max_table #(
  parameter int BUCKET_BITS = rcgmm_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = rcgmm_pkg::WAYS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rcgmm_pkg::KEY_W-1:0] in_group_key,
  input  wire logic [rcgmm_pkg::VAL_W-1:0] in_sample_value,
  input  wire logic                        in_last_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [rcgmm_pkg::KEY_W-1:0] out_key,
  output logic      [rcgmm_pkg::VAL_W-1:0] out_min,
  output logic      [rcgmm_pkg::VAL_W-1:0] out_max,
  output logic                             out_kind,
  output logic                             out_last
);

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int CNT_W       = $clog2(WAYS + 1);
  localparam int ROW_W       = WAYS * rcgmm_pkg::ENT_W + CNT_W;
  localparam int KEY_W       = rcgmm_pkg::KEY_W;
  localparam int VAL_W       = rcgmm_pkg::VAL_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [BUCKET_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic                   run_active_r, run_active_nxt;
  logic [KEY_W-1:0]       run_key_r, run_key_nxt;
  logic [VAL_W-1:0]       run_min_r, run_min_nxt;
  logic [VAL_W-1:0]       run_max_r, run_max_nxt;
  logic [KEY_W-1:0]       itm_key_r, itm_key_nxt;
  logic [VAL_W-1:0]       itm_val_r, itm_val_nxt;
  logic                   itm_last_r, itm_last_nxt;
  logic                   ev_pend_r, ev_pend_nxt;
  logic [KEY_W-1:0]       ev_key_r, ev_key_nxt;
  logic [VAL_W-1:0]       ev_min_r, ev_min_nxt;
  logic [VAL_W-1:0]       ev_max_r, ev_max_nxt;
  logic                   fl_pend_r, fl_pend_nxt;

  logic                   acc;
  logic                   same;
  logic                   run_end;
  logic                   rd_en;
  logic                   wr_en;
  logic [BUCKET_BITS-1:0] wr_addr;
  logic [ROW_W-1:0]       wr_data;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       upd_row;
  rcgmm_pkg::evict_t      upd_ev;
  logic                   push;
  rcgmm_pkg::res_t        push_res;
  logic                   ob_room;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign same     = run_active_r && (in_group_key == run_key_r);
  assign run_end  = run_active_r && !same;
  // row read issued with the closing beat; data arrives in ST_MOD
  assign rd_en    = acc && run_end;
  assign wr_en    = (state_r == ST_CLR) || (state_r == ST_MOD);
  assign wr_addr  = (state_r == ST_CLR) ? clr_addr_r : run_key_r[BUCKET_BITS-1:0];
  assign wr_data  = (state_r == ST_CLR) ? '0 : upd_row;

  rcgmm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (run_key_r[BUCKET_BITS-1:0]),
    .rd_data (rd_row)
  );

  rcgmm_row_upd #(
    .WAYS (WAYS)
  ) u_row_upd (
    .row_in  (rd_row),
    .run_key (run_key_r),
    .run_min (run_min_r),
    .run_max (run_max_r),
    .row_out (upd_row),
    .ev      (upd_ev)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    run_active_nxt = run_active_r;
    run_key_nxt    = run_key_r;
    run_min_nxt    = run_min_r;
    run_max_nxt    = run_max_r;
    itm_key_nxt    = itm_key_r;
    itm_val_nxt    = itm_val_r;
    itm_last_nxt   = itm_last_r;
    ev_pend_nxt    = ev_pend_r;
    ev_key_nxt     = ev_key_r;
    ev_min_nxt     = ev_min_r;
    ev_max_nxt     = ev_max_r;
    fl_pend_nxt    = fl_pend_r;
    push           = 1'b0;
    push_res       = '0;
    case (state_r)
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + BUCKET_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          itm_key_nxt  = in_group_key;
          itm_val_nxt  = in_sample_value;
          itm_last_nxt = in_last_item;
          if (same) begin
            if (in_sample_value < run_min_r) begin
              run_min_nxt = in_sample_value;
            end
            if (in_sample_value > run_max_r) begin
              run_max_nxt = in_sample_value;
            end
          end else if (!run_active_r) begin
            run_active_nxt = 1'b1;
            run_key_nxt    = in_group_key;
            run_min_nxt    = in_sample_value;
            run_max_nxt    = in_sample_value;
          end
          if (run_end) begin
            state_nxt = ST_MOD;
          end else if (in_last_item) begin
            fl_pend_nxt = 1'b1;
            state_nxt   = ST_EMIT;
          end
        end
      end
      ST_MOD: begin
        // row written back this cycle; new run opens from the held beat
        run_key_nxt = itm_key_r;
        run_min_nxt = itm_val_r;
        run_max_nxt = itm_val_r;
        ev_pend_nxt = upd_ev.evict;
        ev_key_nxt  = upd_ev.key;
        ev_min_nxt  = upd_ev.min;
        ev_max_nxt  = upd_ev.max;
        fl_pend_nxt = itm_last_r;
        state_nxt   = (upd_ev.evict || itm_last_r) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (ob_room) begin
          push = 1'b1;
          if (ev_pend_r) begin
            push_res.key  = ev_key_r;
            push_res.min  = ev_min_r;
            push_res.max  = ev_max_r;
            push_res.kind = rcgmm_pkg::KIND_EVICT;
            push_res.last = !fl_pend_r;
            ev_pend_nxt   = 1'b0;
            if (!fl_pend_r) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            push_res.key   = run_key_r;
            push_res.min   = run_min_r;
            push_res.max   = run_max_r;
            push_res.kind  = rcgmm_pkg::KIND_FLUSH;
            push_res.last  = 1'b1;
            fl_pend_nxt    = 1'b0;
            run_active_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_addr_r   <= '0;
      run_active_r <= 1'b0;
      ev_pend_r    <= 1'b0;
      fl_pend_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      run_active_r <= run_active_nxt;
      ev_pend_r    <= ev_pend_nxt;
      fl_pend_r    <= fl_pend_nxt;
    end
    run_key_r  <= run_key_nxt;
    run_min_r  <= run_min_nxt;
    run_max_r  <= run_max_nxt;
    itm_key_r  <= itm_key_nxt;
    itm_val_r  <= itm_val_nxt;
    itm_last_r <= itm_last_nxt;
    ev_key_r   <= ev_key_nxt;
    ev_min_r   <= ev_min_nxt;
    ev_max_r   <= ev_max_nxt;
  end

  rcgmm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .room      (ob_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_key   (out_key),
    .out_min   (out_min),
    .out_max   (out_max),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

[rtl/core/rcgmm_chk.sv]
// ----------------------------------------------------------------------------
// rcgmm_chk
// Port-level checks of the group min/max table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "run_combining_group_min_max_table_assert.svh"

module rcgmm_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rcgmm_pkg::KEY_W-1:0] out_key,
  input wire logic [rcgmm_pkg::VAL_W-1:0] out_min,
  input wire logic [rcgmm_pkg::VAL_W-1:0] out_max,
  input wire logic                        out_kind,
  input wire logic                        out_last
);

  // table clear runs right after reset
  `RCGMM_ASSERT_NR(a_stall_after_reset, clk, !rst_n |=> in_stall, "input not stalled after reset")

  `RCGMM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_min) && $stable(out_max) && $stable(out_kind) && $stable(out_last), "stalled result beat changed")

  `RCGMM_ASSERT(a_flush_is_last, clk, rst_n, out_valid && out_kind |-> out_last, "flush beat without out_last")

  // an eviction not marked last is always followed by its flush
  `RCGMM_ASSERT(a_evict_then_flush, clk, rst_n, out_valid && !out_stall && !out_kind && !out_last |=> out_valid && out_kind, "eviction not followed by flush")

endmodule

bind run_combining_group_min_max_table rcgmm_chk u_rcgmm_chk (.*);

`default_nettype wire

[sim/run_combining_group_min_max_table_tb.sv]
// ----------------------------------------------------------------------------
// run_combining_group_min_max_table_tb
// Self-checking bench for the run-combining group min/max table.
// Tuples go in through a queue-fed driver. A local model of the run register
// and the bucket table predicts each eviction and flush beat. The monitor
// checks every result beat in order. Phases vary sender gaps and receiver
// stalls. Between phases the sender waits until every result is back.
// ----------------------------------------------------------------------------
module run_combining_group_min_max_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LG               = rcgmm_pkg::BUCKET_BITS_DEF;
  localparam int NWAYS            = rcgmm_pkg::WAYS_DEF;
  localparam int KEY_W            = rcgmm_pkg::KEY_W;
  localparam int VAL_W            = rcgmm_pkg::VAL_W;
  localparam int NBUCKETS         = 1 << LG;
  localparam int NENTRIES         = NBUCKETS * NWAYS;
  localparam int LIMIT_CYCLES     = 400000;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int N_HOT            = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
  } tuple_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] in_group_key;
  logic [VAL_W-1:0] in_sample_value;
  logic             in_last_item;
  logic             out_valid;
  logic             out_stall;
  logic [KEY_W-1:0] out_key;
  logic [VAL_W-1:0] out_min;
  logic [VAL_W-1:0] out_max;
  logic             out_kind;
  logic             out_last;

  // open run and bucket table, as the block should hold them
  logic             run_open;
  logic [KEY_W-1:0] run_key;
  logic [VAL_W-1:0] run_lo;
  logic [VAL_W-1:0] run_hi;
  logic             tbl_valid [NENTRIES];
  logic [KEY_W-1:0] tbl_key   [NENTRIES];
  logic [VAL_W-1:0] tbl_lo    [NENTRIES];
  logic [VAL_W-1:0] tbl_hi    [NENTRIES];

  tuple_t           tuples_to_send [$];
  rcgmm_pkg::res_t  aggregates_due [$];
  logic [KEY_W-1:0] hot_keys [N_HOT];

  int idle_pct;
  int stall_pct;
  int error_count;
  int cycle_count;
  int n_tuples;
  int n_evicts;
  int n_flushes;
  bit in_taken;

  run_combining_group_min_max_table #(
    .BUCKET_BITS(LG),
    .WAYS       (NWAYS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_group_key   (in_group_key),
    .in_sample_value(in_sample_value),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key        (out_key),
    .out_min        (out_min),
    .out_max        (out_max),
    .out_kind       (out_kind),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] bucket_key(int tag, int bucket);
    return (KEY_W'(tag) << LG) | KEY_W'(bucket);
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endfunction

  // Fold one accepted tuple into the run, retire the finished run into its
  // bucket, and queue whatever result beats that causes.
  task automatic fold_tuple(input tuple_t t);
    int              base;
    int              j;
    rcgmm_pkg::res_t r;
    if (run_open && t.key == run_key) begin
      if (t.value < run_lo) run_lo = t.value;
      if (t.value > run_hi) run_hi = t.value;
    end else begin
      if (run_open) begin
        base = int'(run_key[LG-1:0]) * NWAYS;
        j = 0;
        while (j < NWAYS && tbl_valid[base+j] && tbl_key[base+j] != run_key) j++;
        if (j < NWAYS && tbl_valid[base+j]) begin
          if (run_lo < tbl_lo[base+j]) tbl_lo[base+j] = run_lo;
          if (run_hi > tbl_hi[base+j]) tbl_hi[base+j] = run_hi;
        end else if (j < NWAYS) begin
          tbl_valid[base+j] = 1'b1;
          tbl_key[base+j]   = run_key;
          tbl_lo[base+j]    = run_lo;
          tbl_hi[base+j]    = run_hi;
        end else begin
          // bucket full: last way leaves, the rest shift down one
          r.key  = tbl_key[base+NWAYS-1];
          r.min  = tbl_lo[base+NWAYS-1];
          r.max  = tbl_hi[base+NWAYS-1];
          r.kind = rcgmm_pkg::KIND_EVICT;
          r.last = !t.last;
          aggregates_due.push_back(r);
          for (int k = NWAYS - 1; k > 0; k--) begin
            tbl_valid[base+k] = tbl_valid[base+k-1];
            tbl_key[base+k]   = tbl_key[base+k-1];
            tbl_lo[base+k]    = tbl_lo[base+k-1];
            tbl_hi[base+k]    = tbl_hi[base+k-1];
          end
          tbl_valid[base] = 1'b1;
          tbl_key[base]   = run_key;
          tbl_lo[base]    = run_lo;
          tbl_hi[base]    = run_hi;
        end
      end
      run_open = 1'b1;
      run_key  = t.key;
      run_lo   = t.value;
      run_hi   = t.value;
    end
    if (t.last) begin
      r.key  = run_key;
      r.min  = run_lo;
      r.max  = run_hi;
      r.kind = rcgmm_pkg::KIND_FLUSH;
      r.last = 1'b1;
      aggregates_due.push_back(r);
      run_open = 1'b0;
    end
  endtask

  task automatic push_tuple(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, logic l);
    tuple_t t;
    t.key   = k;
    t.value = v;
    t.last  = l;
    tuples_to_send.push_back(t);
  endtask

  // Runs of one to four tuples, mostly on a few crowded buckets so that
  // hits, fills and evictions all happen; the rest are random keys.
  task automatic queue_random_runs(input int count);
    int               made;
    int               run_len;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 75) k = hot_keys[$urandom_range(N_HOT - 1)];
      else k = rand64();
      run_len = $urandom_range(1, 4);
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(9))
          0: v = '0;
          1: v = '1;
          default: v = rand64();
        endcase
        push_tuple(k, v, (i == run_len - 1) ? ($urandom_range(99) < 15)
                                            : ($urandom_range(99) < 3));
        made++;
      end
    end
  endtask

  task automatic drain_results();
    while (tuples_to_send.size() != 0 || in_valid || aggregates_due.size() != 0)
      @(negedge clk);
  endtask

  // driver: a new beat is offered only once the previous one was taken
  always @(negedge clk) begin
    tuple_t nxt;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (tuples_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = tuples_to_send.pop_front();
          in_group_key    <= nxt.key;
          in_sample_value <= nxt.value;
          in_last_item    <= nxt.last;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result beats, predict from accepted input beats
  always @(posedge clk) begin
    rcgmm_pkg::res_t want;
    tuple_t          got_in;
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      if (out_kind == rcgmm_pkg::KIND_EVICT) n_evicts++;
      else n_flushes++;
      if (aggregates_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none actual key %h kind %b",
                 $time, out_key, out_kind);
      end else begin
        want = aggregates_due.pop_front();
        check_field("out_key", want.key, out_key);
        check_field("out_min", want.min, out_min);
        check_field("out_max", want.max, out_max);
        check_field("out_kind", 64'(want.kind), 64'(out_kind));
        check_field("out_last", 64'(want.last), 64'(out_last));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      got_in.key   = in_group_key;
      got_in.value = in_sample_value;
      got_in.last  = in_last_item;
      fold_tuple(got_in);
      in_taken = 1'b1;
      n_tuples++;
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, aggregates_due.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_group_key    = '0;
    in_sample_value = '0;
    in_last_item    = 1'b0;
    out_stall       = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    error_count     = 0;
    cycle_count     = 0;
    n_tuples        = 0;
    n_evicts        = 0;
    n_flushes       = 0;
    in_taken        = 1'b0;
    run_open        = 1'b0;
    run_key         = '0;
    run_lo          = '0;
    run_hi          = '0;
    for (int i = 0; i < NENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < N_HOT; i++) begin
      hot_keys[i] = rand64();
      hot_keys[i][LG-1:0] = (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : LG'(37);
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, in-run merge, table hit, fill, full bucket,
    // eviction plus flush on one beat, flush of a lone tuple
    push_tuple('0, '0, 1'b0);
    push_tuple('0, '1, 1'b0);
    push_tuple('1, 64'd5, 1'b0);
    push_tuple('1, '0, 1'b1);
    push_tuple(bucket_key(1, 5), 64'd100, 1'b0);
    push_tuple(bucket_key(2, 5), 64'd50, 1'b0);
    push_tuple(bucket_key(1, 5), 64'd200, 1'b0);
    push_tuple(bucket_key(1, 5), 64'd10, 1'b0);
    push_tuple(bucket_key(3, 5), 64'd1, 1'b0);
    push_tuple(bucket_key(4, 5), 64'd2, 1'b0);
    push_tuple(bucket_key(5, 5), 64'd3, 1'b0);
    push_tuple(bucket_key(2, 5), 64'd9, 1'b0);
    push_tuple(bucket_key(2, 5), 64'd60, 1'b1);
    push_tuple(bucket_key(1, 5), 64'd4, 1'b0);
    push_tuple(bucket_key(3, 5), 64'd8, 1'b1);
    push_tuple(bucket_key(6, 5), 64'd1, 1'b0);
    push_tuple(bucket_key(7, 5), 64'd2, 1'b1);
    push_tuple('1, '1, 1'b1);
    push_tuple({1'b1, 63'd0} | 64'd5, {1'b1, 63'd0}, 1'b0);
    push_tuple({1'b1, 63'd0} | 64'd5, 64'd1, 1'b1);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      queue_random_runs(RANDOM_PER_PHASE);
      // sender holds here until every expected result is back
      drain_results();
    end
    idle_pct  = 0;
    stall_pct = 0;
    repeat (20) @(negedge clk);

    $display("covered %0d tuples over four idle/stall phases", n_tuples);
    $display("checked %0d eviction beats and %0d flush beats, %0d errors",
             n_evicts, n_flushes, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rcgmm_pkg.sv
rtl/core/rcgmm_ram.sv
rtl/core/rcgmm_row_upd.sv
rtl/core/rcgmm_obuf.sv
rtl/core/run_combining_group_min_max_table.sv
rtl/core/rcgmm_chk.sv
sim/run_combining_group_min_max_table_tb.sv
